// ===== rtl/csv_line_field_splitter_defines.svh =====
// ----------------------------------------------------------------------------
// csv_line_field_splitter_defines.svh
// Assertion macros shared by the splitter RTL.
// ----------------------------------------------------------------------------
`ifndef CSV_LINE_FIELD_SPLITTER_DEFINES_SVH
`define CSV_LINE_FIELD_SPLITTER_DEFINES_SVH

// same-cycle implication
`define CSVS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csv splitter check failed");

// next-cycle implication
`define CSVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csv splitter check failed");

`endif

// ===== rtl/csvs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvs_pkg
// Types and constants of the CSV field and line splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] SEP_RESET     = 8'h2C;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_FIELD     = 2'd1,
      KIND_FIELDLINE = 2'd2,
      KIND_LINE      = 2'd3
   } kind_type;

   typedef struct packed {
      logic in_quotes;
      logic quote_pending;
      logic field_nonempty;
   } flags_type;

   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic [7:0] field_byte;
   } result_type;

endpackage

// ===== rtl/csvs_step.sv =====
// ----------------------------------------------------------------------------
// csvs_step
// Combinational decode of one beat: next parser flags and optional result.
// ----------------------------------------------------------------------------
module csvs_step (
   input  logic                 end_of_input,
   input  logic [7:0]           data_byte,
   input  logic [7:0]           separator,
   input  csvs_pkg::flags_type  flags,
   output csvs_pkg::flags_type  flags_next,
   output csvs_pkg::result_type result
);

   logic inq;

   always_comb begin
      inq                       = flags.in_quotes;
      flags_next                = flags;
      flags_next.quote_pending  = 1'b0;
      result.emit               = 1'b0;
      result.kind               = csvs_pkg::KIND_BYTE;
      result.field_byte         = '0;

      if (flags.quote_pending && !end_of_input && data_byte == csvs_pkg::CH_QUOTE) begin
         // doubled quote
         result.emit               = 1'b1;
         result.field_byte         = csvs_pkg::CH_QUOTE;
         flags_next.field_nonempty = 1'b1;
      end else begin
         if (flags.quote_pending) begin
            inq = 1'b0;
         end
         flags_next.in_quotes = inq;

         priority if (end_of_input || (data_byte == csvs_pkg::CH_NEWLINE && !inq)) begin
            result.emit               = 1'b1;
            result.kind               = flags.field_nonempty ? csvs_pkg::KIND_FIELDLINE
                                                             : csvs_pkg::KIND_LINE;
            flags_next.in_quotes      = 1'b0;
            flags_next.field_nonempty = 1'b0;
         end else if (data_byte == csvs_pkg::CH_NEWLINE) begin
            result.emit               = 1'b1;
            result.field_byte         = data_byte;
            flags_next.field_nonempty = 1'b1;
         end else if (data_byte == separator && !inq) begin
            result.emit               = 1'b1;
            result.kind               = csvs_pkg::KIND_FIELD;
            flags_next.field_nonempty = 1'b0;
         end else if (data_byte == csvs_pkg::CH_QUOTE) begin
            if (inq) begin
               flags_next.quote_pending = 1'b1;
            end else begin
               flags_next.in_quotes = 1'b1;
            end
         end else if (data_byte == csvs_pkg::CH_CR) begin
            result.emit = 1'b0;
         end else begin
            result.emit               = 1'b1;
            result.field_byte         = data_byte;
            flags_next.field_nonempty = 1'b1;
         end
      end
   end

endmodule

// ===== rtl/csv_line_field_splitter.sv =====
// ----------------------------------------------------------------------------
// csv_line_field_splitter
// CSV field and line splitter, one byte per cycle unless rsp_ready stalls.
// ----------------------------------------------------------------------------
// Input beats (req_) carry one text byte or an end-of-input mark. Result
// beats (rsp_) carry a field byte, a field end, a field end plus line end,
// or a line end alone. Opening and closing quotes, the first quote of a
// doubled quote and CR are consumed without a result beat.
// csr_write_enable loads the separator byte (comma after reset); write it
// only while the block is idle.
// A beat accepted into the input register is decoded from it, and its result, if
// any, is loaded into the result register when that register is free or taken.
// Throughput: one beat per cycle while not stalled; the flag update for one beat
// is a single compare-and-select level between the input and result registers.
// A stalled rsp_ready holds the result register; the input register keeps
// its beat or takes one if empty, and req_ready is low until the result is taken.
// Synchronous reset clears both registers' valid flags, the parser flags
// and sets the separator back to comma.
// ----------------------------------------------------------------------------
`include "csv_line_field_splitter_defines.svh"

module csv_line_field_splitter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_field_byte,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_eoi_ff;
   logic [7:0]           sep_ff;
   csvs_pkg::flags_type  flags_ff, flags_in;
   logic                 out_valid_ff, out_valid_in;
   csvs_pkg::kind_type   out_kind_ff;
   logic [7:0]           out_byte_ff;
   csvs_pkg::result_type step_result;
   logic                 advance;

   csvs_step u_step (
      .end_of_input (in_eoi_ff),
      .data_byte    (in_byte_ff),
      .separator    (sep_ff),
      .flags        (flags_ff),
      .flags_next   (flags_in),
      .result       (step_result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && step_result.emit) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         sep_ff       <= csvs_pkg::SEP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
         if (csr_write_enable) begin
            sep_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eoi_ff  <= req_end_of_input;
      end
      if (advance && step_result.emit) begin
         out_kind_ff <= step_result.kind;
         out_byte_ff <= step_result.field_byte;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_field_byte = out_byte_ff;

   `CSVS_ASSERT_IMPLY(a_pending_in_quotes, clock, reset, flags_ff.quote_pending,
                      flags_ff.in_quotes)
   `CSVS_ASSERT_IMPLY(a_marker_zero_byte, clock, reset,
                      out_valid_ff && out_kind_ff != csvs_pkg::KIND_BYTE,
                      out_byte_ff == 8'd0)
   `CSVS_ASSERT_NEXT(a_line_end_clears, clock, reset,
                     advance && step_result.emit &&
                     (step_result.kind == csvs_pkg::KIND_FIELDLINE ||
                      step_result.kind == csvs_pkg::KIND_LINE),
                     !flags_ff.in_quotes && !flags_ff.field_nonempty)
   `CSVS_ASSERT_NEXT(a_in_held, clock, reset, in_valid_ff && !advance,
                     in_valid_ff && $stable(in_byte_ff) && $stable(in_eoi_ff))
   `CSVS_ASSERT_IMPLY(a_no_drop, clock, reset, advance && step_result.emit,
                      !out_valid_ff || rsp_ready)

endmodule
